// ===== src/block_cache_lru_pin_manager_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the buffer pool tag manager
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_LRU_PIN_MANAGER_ASSERT_SVH
`define BLOCK_CACHE_LRU_PIN_MANAGER_ASSERT_SVH

// Property holds at every edge.
`define BLKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define BLKC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/blkc_pkg.sv =====
// ----------------------------------------------------------------------------
// blkc_pkg
// Shared sizes, operation codes and the queued request type.
// ----------------------------------------------------------------------------
package blkc_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned FILE_BITS = 8;
  localparam int unsigned OFF_BITS  = 16;
  localparam int unsigned SW        = $clog2(NUM_SLOTS);
  localparam int unsigned CW        = $clog2(NUM_SLOTS + 1);
  // Queue depth, a power of two.
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPW       = $clog2(QDEPTH);
  localparam int unsigned QCW       = $clog2(QDEPTH + 1);

  localparam logic [2:0] FUNC_REQUEST = 3'd0;
  localparam logic [2:0] FUNC_UNPIN   = 3'd1;
  localparam logic [2:0] FUNC_PIN     = 3'd2;
  localparam logic [2:0] FUNC_DIRTY   = 3'd3;
  localparam logic [2:0] FUNC_DROP    = 3'd4;
  localparam logic [2:0] FUNC_FLUSH   = 3'd5;

  typedef enum logic [2:0] {
    OP_REQUEST = 3'd0,
    OP_UNPIN   = 3'd1,
    OP_PIN     = 3'd2,
    OP_DIRTY   = 3'd3,
    OP_DROP    = 3'd4,
    OP_FLUSH   = 3'd5
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [FILE_BITS-1:0] file;
    logic [OFF_BITS-1:0]  off;
    logic                 slot_ok;
    logic [SW-1:0]        slot;
  } item_t;

endpackage

// ===== src/blkc_front.sv =====
// ----------------------------------------------------------------------------
// blkc_front
// Accepts requests, decodes the function code and queues them for the back.
// ----------------------------------------------------------------------------
module blkc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          func_i,
  input  logic [7:0]          file_id_i,
  input  logic [15:0]         block_offset_i,
  input  logic [3:0]          slot_index_i,
  output blkc_pkg::item_t     item_o,
  output logic                item_valid_o,
  input  logic                item_pop_i
);

  localparam int unsigned FILE_BITS = blkc_pkg::FILE_BITS;
  localparam int unsigned OFF_BITS  = blkc_pkg::OFF_BITS;
  localparam int unsigned SW        = blkc_pkg::SW;
  localparam int unsigned QPW       = blkc_pkg::QPW;
  localparam int unsigned QCW       = blkc_pkg::QCW;

  blkc_pkg::item_t mem_q [blkc_pkg::QDEPTH];
  logic [QPW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]  cnt_q, cnt_d;
  blkc_pkg::item_t dec;
  logic            dec_ok, accept, push, pop;

  always_comb begin
    dec_ok  = 1'b1;
    dec.op  = blkc_pkg::OP_REQUEST;
    dec.file    = FILE_BITS'(file_id_i);
    dec.off     = OFF_BITS'(block_offset_i);
    dec.slot_ok = 32'(slot_index_i) < blkc_pkg::NUM_SLOTS;
    dec.slot    = SW'(slot_index_i);
    unique case (func_i)
      blkc_pkg::FUNC_REQUEST: dec.op = blkc_pkg::OP_REQUEST;
      blkc_pkg::FUNC_UNPIN:   dec.op = blkc_pkg::OP_UNPIN;
      blkc_pkg::FUNC_PIN:     dec.op = blkc_pkg::OP_PIN;
      blkc_pkg::FUNC_DIRTY:   dec.op = blkc_pkg::OP_DIRTY;
      blkc_pkg::FUNC_DROP:    dec.op = blkc_pkg::OP_DROP;
      blkc_pkg::FUNC_FLUSH:   dec.op = blkc_pkg::OP_FLUSH;
      default:                dec_ok = 1'b0; // drop unused codes
    endcase
  end

  assign in_stall_o   = cnt_q == QCW'(blkc_pkg::QDEPTH);
  assign accept       = in_valid_i && !in_stall_o;
  assign push         = accept && dec_ok;
  assign item_valid_o = cnt_q != '0;
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= dec;
  end

endmodule

// ===== src/blkc_back.sv =====
// ----------------------------------------------------------------------------
// blkc_back
// Holds the slot tags and recency list, executes queued requests, registers results.
// ----------------------------------------------------------------------------
`include "block_cache_lru_pin_manager_assert.svh"

module blkc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  blkc_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            hit_o,
  output logic            fetch_o,
  output logic [3:0]      slot_o,
  output logic            writeback_o,
  output logic [7:0]      wb_file_o,
  output logic [15:0]     wb_offset_o,
  output logic            all_pinned_o,
  output logic            last_o
);

  localparam int unsigned NUM_SLOTS = blkc_pkg::NUM_SLOTS;
  localparam int unsigned FILE_BITS = blkc_pkg::FILE_BITS;
  localparam int unsigned OFF_BITS  = blkc_pkg::OFF_BITS;
  localparam int unsigned SW        = blkc_pkg::SW;
  localparam int unsigned CW        = blkc_pkg::CW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_UPD   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, pinned_q, dirty_q;
  logic [FILE_BITS-1:0] tag_file_q [NUM_SLOTS];
  logic [OFF_BITS-1:0]  tag_off_q  [NUM_SLOTS];
  logic [SW-1:0]        order_q    [NUM_SLOTS];
  logic [CW-1:0]        used_q;
  blkc_pkg::item_t      cur_q;

  logic                 hit_q, vic_ok_q;
  logic [SW-1:0]        hit_slot_q, hit_pos_q, vic_pos_q;

  logic                 out_valid_q, o_hit_q, o_fetch_q, o_wb_q, o_ap_q, o_last_q;
  logic [SW-1:0]        o_slot_q;
  logic [FILE_BITS-1:0] o_wbf_q;
  logic [OFF_BITS-1:0]  o_wbo_q;

  logic [NUM_SLOTS-1:0] match_vec, fmask;
  logic                 hit_any, vic_ok, full, out_free, fany, frest, hit_emit;
  logic [SW-1:0]        hit_slot, hit_pos, vic_pos, fslot;

  logic                 emit, e_hit, e_fetch, e_wb, e_ap, e_last;
  logic [SW-1:0]        e_slot;
  logic [FILE_BITS-1:0] e_wbf;
  logic [OFF_BITS-1:0]  e_wbo;
  logic                 claim_en, pin_set, shift_en, used_inc, flush_clr;
  logic [SW-1:0]        claim_slot, pin_slot, shift_pos, shift_slot;

  assign full     = used_q == CW'(NUM_SLOTS);
  assign out_free = !out_valid_q || !out_stall_i;
  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;
  assign hit_emit = (state_q == S_UPD) && out_free && hit_q;

  // Tag match, hit position in the recency list, LRU unpinned victim.
  always_comb begin
    hit_slot = '0;
    hit_pos  = SW'(NUM_SLOTS - 1);
    vic_ok   = 1'b0;
    vic_pos  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_vec[i] = valid_q[i] && (tag_file_q[i] == cur_q.file) &&
                     (tag_off_q[i] == cur_q.off);
    end
    hit_any = |match_vec;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_slot = SW'(i);
    end
    for (int p = NUM_SLOTS - 1; p >= 0; p--) begin
      if (CW'(p) < used_q && match_vec[order_q[p]]) hit_pos = SW'(p);
    end
    for (int p = 0; p < NUM_SLOTS; p++) begin
      if (!pinned_q[order_q[p]]) begin
        vic_ok  = 1'b1;
        vic_pos = SW'(p);
      end
    end
  end

  // Lowest valid dirty slot for flush.
  always_comb begin
    fmask = valid_q & dirty_q;
    fany  = |fmask;
    fslot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (fmask[i]) fslot = SW'(i);
    end
    frest = |(fmask & ~(NUM_SLOTS'(1) << fslot));
  end

  always_comb begin
    state_d    = state_q;
    emit       = 1'b0;
    e_hit      = 1'b0;
    e_fetch    = 1'b0;
    e_slot     = '0;
    e_wb       = 1'b0;
    e_wbf      = '0;
    e_wbo      = '0;
    e_ap       = 1'b0;
    e_last     = 1'b1;
    claim_en   = 1'b0;
    claim_slot = '0;
    pin_set    = 1'b0;
    pin_slot   = '0;
    shift_en   = 1'b0;
    shift_pos  = '0;
    shift_slot = '0;
    used_inc   = 1'b0;
    flush_clr  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          if (item_i.op == blkc_pkg::OP_REQUEST) state_d = S_LOOK;
          else if (item_i.op == blkc_pkg::OP_FLUSH) state_d = S_FLUSH;
        end
      end
      S_LOOK: state_d = S_UPD;
      S_UPD: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          priority if (hit_q) begin
            e_hit      = 1'b1;
            e_slot     = hit_slot_q;
            pin_set    = 1'b1;
            pin_slot   = hit_slot_q;
            shift_en   = 1'b1;
            shift_pos  = hit_pos_q;
            shift_slot = hit_slot_q;
          end else if (!full) begin
            e_fetch    = 1'b1;
            e_slot     = SW'(used_q);
            claim_en   = 1'b1;
            claim_slot = SW'(used_q);
            shift_en   = 1'b1;
            shift_pos  = SW'(used_q);
            shift_slot = SW'(used_q);
            used_inc   = 1'b1;
          end else if (vic_ok_q) begin
            e_fetch    = 1'b1;
            e_slot     = order_q[vic_pos_q];
            e_wb       = valid_q[order_q[vic_pos_q]] && dirty_q[order_q[vic_pos_q]];
            e_wbf      = e_wb ? tag_file_q[order_q[vic_pos_q]] : '0;
            e_wbo      = e_wb ? tag_off_q[order_q[vic_pos_q]] : '0;
            claim_en   = 1'b1;
            claim_slot = order_q[vic_pos_q];
            shift_en   = 1'b1;
            shift_pos  = vic_pos_q;
            shift_slot = order_q[vic_pos_q];
          end else begin
            e_ap = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!fany) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          e_slot    = fslot;
          e_wb      = 1'b1;
          e_wbf     = tag_file_q[fslot];
          e_wbo     = tag_off_q[fslot];
          e_last    = !frest;
          flush_clr = 1'b1;
          if (!frest) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      pinned_q    <= '0;
      dirty_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (used_inc) used_q <= used_q + 1'b1;
      if (item_pop_o) begin
        unique case (item_i.op)
          blkc_pkg::OP_UNPIN: if (item_i.slot_ok) pinned_q[item_i.slot] <= 1'b0;
          blkc_pkg::OP_PIN:   if (item_i.slot_ok) pinned_q[item_i.slot] <= 1'b1;
          blkc_pkg::OP_DIRTY: if (item_i.slot_ok) dirty_q[item_i.slot] <= 1'b1;
          blkc_pkg::OP_DROP: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (CW'(i) < used_q && tag_file_q[i] == item_i.file) valid_q[i] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (pin_set) pinned_q[pin_slot] <= 1'b1;
      if (claim_en) begin
        valid_q[claim_slot]  <= 1'b1;
        pinned_q[claim_slot] <= 1'b1;
        dirty_q[claim_slot]  <= 1'b0;
      end
      if (flush_clr) dirty_q[fslot] <= 1'b0;
    end
  end

  // Payload registers: tags, recency list, latched request, results.
  always_ff @(posedge clk_i) begin
    if (item_pop_o) cur_q <= item_i;
    if (state_q == S_LOOK) begin
      hit_q      <= hit_any;
      hit_slot_q <= hit_slot;
      hit_pos_q  <= hit_pos;
      vic_ok_q   <= vic_ok;
      vic_pos_q  <= vic_pos;
    end
    if (claim_en) begin
      tag_file_q[claim_slot] <= cur_q.file;
      tag_off_q[claim_slot]  <= cur_q.off;
    end
    // Move the chosen entry to the front, shift the ones ahead of it back.
    if (shift_en) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j == 0) order_q[j] <= shift_slot;
        else if (SW'(j) <= shift_pos) order_q[j] <= order_q[j-1];
      end
    end
    if (emit) begin
      o_hit_q   <= e_hit;
      o_fetch_q <= e_fetch;
      o_slot_q  <= e_slot;
      o_wb_q    <= e_wb;
      o_wbf_q   <= e_wbf;
      o_wbo_q   <= e_wbo;
      o_ap_q    <= e_ap;
      o_last_q  <= e_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = o_hit_q;
  assign fetch_o      = o_fetch_q;
  assign slot_o       = 4'(o_slot_q);
  assign writeback_o  = o_wb_q;
  assign wb_file_o    = 8'(o_wbf_q);
  assign wb_offset_o  = 16'(o_wbo_q);
  assign all_pinned_o = o_ap_q;
  assign last_o       = o_last_q;

  `BLKC_ASSERT(a_used_bound, used_q <= CW'(NUM_SLOTS), "slot fill count overflow")
  `BLKC_ASSERT(a_valid_in_used, (valid_q >> used_q) == '0, "valid slot beyond fill count")
  `BLKC_ASSERT_NEXT(a_hit_result, hit_emit, out_valid_q && o_hit_q && !o_fetch_q, "hit result")

endmodule

// ===== src/block_cache_lru_pin_manager.sv =====
// ----------------------------------------------------------------------------
// block_cache_lru_pin_manager
// Buffer pool tag manager with LRU replacement and slot pinning.
// ----------------------------------------------------------------------------
// A request is queued, popped while the back is idle, looked up, and its result is
// registered in the update state; the back takes no new item until it is idle again.
// Pin, unpin, dirty and drop apply when popped; flush emits a writeback per dirty slot.
// A 2-entry queue decouples intake from execution.
// Reset clears valid, pinned, dirty bits and the fill count; no clearing pass.
module block_cache_lru_pin_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  file_id_i,
  input  logic [15:0] block_offset_i,
  input  logic [3:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        fetch_o,
  output logic [3:0]  slot_o,
  output logic        writeback_o,
  output logic [7:0]  wb_file_o,
  output logic [15:0] wb_offset_o,
  output logic        all_pinned_o,
  output logic        last_o
);

  blkc_pkg::item_t item;
  logic            item_valid;
  logic            item_pop;

  blkc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .file_id_i      (file_id_i),
    .block_offset_i (block_offset_i),
    .slot_index_i   (slot_index_i),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop)
  );

  blkc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .fetch_o      (fetch_o),
    .slot_o       (slot_o),
    .writeback_o  (writeback_o),
    .wb_file_o    (wb_file_o),
    .wb_offset_o  (wb_offset_o),
    .all_pinned_o (all_pinned_o),
    .last_o       (last_o)
  );

endmodule

// ===== dv/block_cache_lru_pin_manager_tb.sv =====
// ----------------------------------------------------------------------------
// block_cache_lru_pin_manager_tb
// Drives random and directed operations into the buffer pool tag manager,
// predicts each result with a behavioral tag/recency model and checks the
// results in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module block_cache_lru_pin_manager_tb;

  localparam int NSLOT = 16;
  localparam int MAXRES = 16;

  typedef struct packed {
    logic        hit;
    logic        fetch;
    logic [3:0]  slot;
    logic        writeback;
    logic [7:0]  wb_file;
    logic [15:0] wb_offset;
    logic        all_pinned;
    logic        last;
  } res_t;

  class pool_scoreboard;
    bit          valid_q[NSLOT];
    bit          pinned_q[NSLOT];
    bit          dirty_q[NSLOT];
    logic [7:0]  tfile[NSLOT];
    logic [15:0] toff[NSLOT];
    int          used;
    int          lru[NSLOT];
    res_t        pending[$];
    int          errors;

    function new();
      used = 0;
      errors = 0;
      for (int i = 0; i < NSLOT; i++) begin
        valid_q[i] = 0; pinned_q[i] = 0; dirty_q[i] = 0;
        tfile[i] = '0; toff[i] = '0; lru[i] = 0;
      end
    endfunction

    function void promote(int pos, int s);
      for (int p = pos; p > 0; p--) lru[p] = lru[p-1];
      lru[0] = s;
    endfunction

    function void grant(int s, logic [7:0] f, logic [15:0] o);
      valid_q[s] = 1; pinned_q[s] = 1; dirty_q[s] = 0;
      tfile[s] = f; toff[s] = o;
    endfunction

    function void note_op(blkc_pkg::op_e op, logic [7:0] f, logic [15:0] o,
                          logic [3:0] si);
      res_t r;
      int n;
      int pos;
      int v;
      r = '0;
      case (op)
        blkc_pkg::OP_REQUEST: begin
          for (int i = 0; i < used; i++) begin
            if (valid_q[i] && tfile[i] == f && toff[i] == o) begin
              pos = 0;
              while (pos < used && lru[pos] != i) pos++;
              promote(pos, i);
              pinned_q[i] = 1;
              r.hit = 1; r.slot = 4'(i); r.last = 1;
              pending.push_back(r);
              return;
            end
          end
          if (used < NSLOT) begin
            grant(used, f, o);
            promote(used, used);
            r.fetch = 1; r.slot = 4'(used); r.last = 1;
            used++;
            pending.push_back(r);
            return;
          end
          for (pos = NSLOT - 1; pos >= 0; pos--) begin
            v = lru[pos];
            if (!pinned_q[v]) begin
              if (valid_q[v] && dirty_q[v]) begin
                r.writeback = 1; r.wb_file = tfile[v]; r.wb_offset = toff[v];
              end
              grant(v, f, o);
              promote(pos, v);
              r.fetch = 1; r.slot = 4'(v); r.last = 1;
              pending.push_back(r);
              return;
            end
          end
          r.all_pinned = 1; r.last = 1;
          pending.push_back(r);
        end
        blkc_pkg::OP_UNPIN: pinned_q[si] = 0;
        blkc_pkg::OP_PIN:   pinned_q[si] = 1;
        blkc_pkg::OP_DIRTY: dirty_q[si] = 1;
        blkc_pkg::OP_DROP: begin
          for (int i = 0; i < used; i++) if (tfile[i] == f) valid_q[i] = 0;
        end
        blkc_pkg::OP_FLUSH: begin
          n = 0;
          for (int i = 0; i < used && n < MAXRES; i++) begin
            if (valid_q[i] && dirty_q[i]) begin
              r = '0;
              r.slot = 4'(i); r.writeback = 1; r.wb_file = tfile[i]; r.wb_offset = toff[i];
              pending.push_back(r);
              dirty_q[i] = 0;
              n++;
            end
          end
          if (n > 0) pending[pending.size()-1].last = 1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
      end
      if (a.fetch !== e.fetch) begin
        $error("fetch exp %0d got %0d", e.fetch, a.fetch); errors++;
      end
      if (a.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
      end
      if (a.writeback !== e.writeback) begin
        $error("writeback exp %0d got %0d", e.writeback, a.writeback); errors++;
      end
      if (a.wb_file !== e.wb_file) begin
        $error("wb_file exp %0h got %0h", e.wb_file, a.wb_file); errors++;
      end
      if (a.wb_offset !== e.wb_offset) begin
        $error("wb_offset exp %0h got %0h", e.wb_offset, a.wb_offset); errors++;
      end
      if (a.all_pinned !== e.all_pinned) begin
        $error("all_pinned exp %0d got %0d", e.all_pinned, a.all_pinned); errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [7:0]  file_id_i = '0;
  logic [15:0] block_offset_i = '0;
  logic [3:0]  slot_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o, fetch_o, writeback_o, all_pinned_o, last_o;
  logic [3:0]  slot_o;
  logic [7:0]  wb_file_o;
  logic [15:0] wb_offset_o;

  pool_scoreboard pool_sb;
  bit  calm = 0;        // no idling on either side
  int  hold_cycles = 0; // long receiver hold-off

  always #2 clk_i = ~clk_i;

  block_cache_lru_pin_manager i_dut (.*);

  // Receiver: random stalls, plus a long hold-off on demand.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      pool_sb.check_result({hit_o, fetch_o, slot_o, writeback_o, wb_file_o,
                            wb_offset_o, all_pinned_o, last_o});
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 19);
    end
  end

  task automatic send_op(blkc_pkg::op_e op, logic [7:0] f, logic [15:0] o,
                         logic [3:0] si);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    file_id_i <= f;
    block_offset_i <= o;
    slot_index_i <= si;
    do @(posedge clk_i); while (in_stall_o);
    pool_sb.note_op(op, f, o, si);
  endtask

  task automatic send_raw(logic [2:0] fc);
    in_valid_i <= 1'b1;
    func_i <= fc;
    file_id_i <= 8'($urandom);
    block_offset_i <= 16'($urandom);
    slot_index_i <= 4'($urandom);
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    #400000;
    $display("block_cache_lru_pin_manager_tb NOT OK");
    $finish;
  end

  initial begin
    int r;
    blkc_pkg::op_e op;
    pool_sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill, hits, extremes, all pinned, eviction with writeback.
    send_op(blkc_pkg::OP_REQUEST, 8'hFF, 16'hFFFF, 4'd0);
    send_op(blkc_pkg::OP_REQUEST, 8'h00, 16'h0000, 4'd0);
    send_op(blkc_pkg::OP_REQUEST, 8'hFF, 16'hFFFF, 4'd0);
    send_op(blkc_pkg::OP_DIRTY, 8'h00, 16'h0, 4'd0);
    send_op(blkc_pkg::OP_DIRTY, 8'h00, 16'h0, 4'd15);
    send_op(blkc_pkg::OP_FLUSH, 8'h00, 16'h0, 4'd0);
    send_op(blkc_pkg::OP_FLUSH, 8'h00, 16'h0, 4'd0);
    for (int i = 0; i < 15; i++) send_op(blkc_pkg::OP_REQUEST, 8'hA5, 16'(i), 4'd0);
    send_op(blkc_pkg::OP_REQUEST, 8'h5A, 16'h5A5A, 4'd0);
    send_op(blkc_pkg::OP_UNPIN, 8'h0, 16'h0, 4'd0);
    send_op(blkc_pkg::OP_DIRTY, 8'h0, 16'h0, 4'd0);
    send_op(blkc_pkg::OP_DROP, 8'hA5, 16'h0, 4'd0);
    send_op(blkc_pkg::OP_UNPIN, 8'h0, 16'h0, 4'd3);
    send_op(blkc_pkg::OP_REQUEST, 8'h11, 16'h2222, 4'd0);
    send_raw(3'd6);
    send_raw(3'd7);

    // Pressure: hold the receiver while requests keep coming.
    calm = 1;
    hold_cycles = 60;
    for (int i = 0; i < 8; i++) send_op(blkc_pkg::OP_REQUEST, 8'hFF, 16'hFFFF, 4'd0);

    // Random: requests most often, mostly on a small tag set, with release of pins.
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 220);
      r = $urandom_range(99);
      if (r < 45) op = blkc_pkg::OP_REQUEST;
      else if (r < 70) op = blkc_pkg::OP_UNPIN;
      else if (r < 78) op = blkc_pkg::OP_PIN;
      else if (r < 88) op = blkc_pkg::OP_DIRTY;
      else if (r < 93) op = blkc_pkg::OP_DROP;
      else op = blkc_pkg::OP_FLUSH;
      if ($urandom_range(9) == 0)
        send_op(op, 8'($urandom), 16'($urandom), 4'($urandom));
      else
        send_op(op, 8'($urandom_range(3)), 16'($urandom_range(11)), 4'($urandom));
    end
    in_valid_i <= 1'b0;
    calm = 0;

    while (pool_sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (pool_sb.errors == 0)
      $display("block_cache_lru_pin_manager_tb OK");
    else
      $display("block_cache_lru_pin_manager_tb NOT OK");
    $finish;
  end
endmodule
